// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the running statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is high.
`define RMV_ASSERT_IMP(NAME, ANT, CON) \
  NAME: assert property (@(posedge clk) disable iff (rst) (ANT) |-> (CON)) \
    else $error("running statistics check failed");

// Next-cycle implication, inactive while reset is high.
`define RMV_ASSERT_NXT(NAME, ANT, CON) \
  NAME: assert property (@(posedge clk) disable iff (rst) (ANT) |=> (CON)) \
    else $error("running statistics check failed");

// Next-cycle implication that also covers the reset cycles.
`define RMV_ASSERT_RST(NAME, ANT, CON) \
  NAME: assert property (@(posedge clk) (ANT) |=> (CON)) \
    else $error("running statistics reset check failed");

`endif

// ===== rtl/rmv_pkg.sv =====
// Package of the running mean and variance block: widths, step counts, control structs.
package rmv_pkg;

  // Payload and state widths
  localparam int SAMPLE_W   = 32;
  localparam int MEAN_EXTRA = 16;
  localparam int MEAN_W     = SAMPLE_W + MEAN_EXTRA;
  localparam int SUM_W      = 64;
  localparam int TOTAL_W    = 32;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int COUNT_BITS_DEF = 32;

  // Deviation product: built from four half-width partial products
  localparam int PART_W     = MEAN_W / 2;
  localparam int PROD_W     = 2 * MEAN_W;
  localparam int TERM_SHIFT = 32;

  // Sequencer step counts
  localparam int STEP_W     = 6;
  localparam int DIV_STEPS  = SUM_W;
  localparam int MUL_CYCLES = 5;
  localparam int ROOT_STEPS = ROOT_W;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       take;          // capture sample, count it
    logic       delta;         // first deviation, load divider with it
    logic       div_step;      // one restoring division step
    logic       mean_upd;      // apply quotient to mean, clear product
    logic       delta2;        // deviation from the new mean
    logic       mul_go;        // form one partial product
    logic [1:0] mul_idx;       // which partial product
    logic       mul_acc;       // accumulate the registered partial product
    logic       sum_upd;       // saturating add into the deviation sum
    logic       div_load_var;  // load divider with sum / (count - 1)
    logic       var_zero;      // variance is zero below two samples
    logic       root_init;     // start the square root
    logic       root_step;     // one square root digit
    logic       publish;       // load the result register
  } rmv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic multi;               // at least two samples counted
  } rmv_stat_t;

endpackage

// ===== rtl/rmv_sample_if.sv =====
// Valid/ready channel carrying one input sample.
interface rmv_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmv_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/rmv_result_if.sv =====
// Valid/ready channel carrying one statistics result.
interface rmv_result_if;
  logic                                valid;
  logic                                ready;
  logic        [rmv_pkg::TOTAL_W-1:0]  sample_total;
  logic signed [rmv_pkg::SAMPLE_W-1:0] mean_out;
  logic        [rmv_pkg::SUM_W-1:0]    variance_out;
  logic        [rmv_pkg::ROOT_W-1:0]   stddev_out;

  modport source (output valid, output sample_total, output mean_out,
                  output variance_out, output stddev_out, input ready);
  modport sink   (input valid, input sample_total, input mean_out,
                  input variance_out, input stddev_out, output ready);
endinterface

// ===== rtl/running_mean_variance.sv =====
// Running mean and variance (Welford) over signed Q16.16 samples: one result per sample,
// giving the saturating count, the mean (Q16.16, floored), the sample variance (Q32.32,
// zero below two samples) and its square root (Q16.16, floored). The next sample is taken
// only once the previous one has gone through the one radix-2 divider, for the mean step
// and, once two samples have been counted, for the variance, and through the square root.
// The result sits in an output register, so a new sample is taken while the previous
// result still waits. COUNT_BITS sets the width of the sample counter.
module running_mean_variance #(
  parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  rmv_sample_if.sink   sample_ch,
  rmv_result_if.source result_ch
);

  rmv_pkg::rmv_cmd_t  cmd;
  rmv_pkg::rmv_stat_t stat;

  // Sequencer
  rmv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_ch.valid),
    .sample_ready (sample_ch.ready),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Arithmetic and state
  rmv_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample_ch.sample),
    .sample_total (result_ch.sample_total),
    .mean_out     (result_ch.mean_out),
    .variance_out (result_ch.variance_out),
    .stddev_out   (result_ch.stddev_out)
  );

endmodule

// ===== rtl/rmv_ctrl.sv =====
// Sequencer of the running statistics block: steps the datapath through one sample.
module rmv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  output logic              result_valid,
  input  logic              result_ready,
  output rmv_pkg::rmv_cmd_t cmd,
  input  rmv_pkg::rmv_stat_t stat
);

  typedef enum logic [3:0] {
    IDLE, DELTA, DIV_MEAN, MEAN_UPD, DELTA2, MUL, SUM, VAR,
    DIV_VAR, ROOT_INIT, ROOT, PUBLISH
  } state_t;

  localparam logic [rmv_pkg::STEP_W-1:0] DIV_LAST =
    rmv_pkg::STEP_W'(rmv_pkg::DIV_STEPS - 1);
  localparam logic [rmv_pkg::STEP_W-1:0] MUL_LAST =
    rmv_pkg::STEP_W'(rmv_pkg::MUL_CYCLES - 1);
  localparam logic [rmv_pkg::STEP_W-1:0] MUL_PARTS =
    rmv_pkg::STEP_W'(rmv_pkg::MUL_CYCLES - 1);
  localparam logic [rmv_pkg::STEP_W-1:0] ROOT_LAST =
    rmv_pkg::STEP_W'(rmv_pkg::ROOT_STEPS - 1);

  state_t                      state;
  logic [rmv_pkg::STEP_W-1:0]  step;
  logic                        out_free;

  assign out_free     = !result_valid || result_ready;
  assign sample_ready = (state == IDLE) && !rst;

  // Command decode
  always_comb begin
    cmd              = '0;
    cmd.take         = (state == IDLE) && sample_valid && !rst;
    cmd.delta        = (state == DELTA);
    cmd.div_step     = (state == DIV_MEAN) || (state == DIV_VAR);
    cmd.mean_upd     = (state == MEAN_UPD);
    cmd.delta2       = (state == DELTA2);
    cmd.mul_go       = (state == MUL) && (step < MUL_PARTS);
    cmd.mul_idx      = step[1:0];
    cmd.mul_acc      = (state == MUL) && (step != '0);
    cmd.sum_upd      = (state == SUM);
    cmd.div_load_var = (state == VAR) && stat.multi;
    cmd.var_zero     = (state == VAR) && !stat.multi;
    cmd.root_init    = (state == ROOT_INIT);
    cmd.root_step    = (state == ROOT);
    cmd.publish      = (state == PUBLISH) && out_free;
  end

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          step <= '0;
          if (sample_valid) begin
            state <= DELTA;
          end
        end
        DELTA: begin
          step  <= '0;
          state <= DIV_MEAN;
        end
        DIV_MEAN: begin
          step <= step + 1'b1;
          if (step == DIV_LAST) begin
            state <= MEAN_UPD;
          end
        end
        MEAN_UPD: begin
          state <= DELTA2;
        end
        DELTA2: begin
          step  <= '0;
          state <= MUL;
        end
        MUL: begin
          step <= step + 1'b1;
          if (step == MUL_LAST) begin
            state <= SUM;
          end
        end
        SUM: begin
          state <= VAR;
        end
        VAR: begin
          step  <= '0;
          state <= stat.multi ? DIV_VAR : ROOT_INIT;
        end
        DIV_VAR: begin
          step <= step + 1'b1;
          if (step == DIV_LAST) begin
            state <= ROOT_INIT;
          end
        end
        ROOT_INIT: begin
          step  <= '0;
          state <= ROOT;
        end
        ROOT: begin
          step <= step + 1'b1;
          if (step == ROOT_LAST) begin
            state <= PUBLISH;
          end
        end
        PUBLISH: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/rmv_dp.sv =====
// Datapath of the running statistics block: state, shared divider, multiplier, square root.
module rmv_dp #(
  parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rmv_pkg::rmv_cmd_t                   cmd,
  output rmv_pkg::rmv_stat_t                  stat,
  input  logic signed [rmv_pkg::SAMPLE_W-1:0] sample,
  output logic        [rmv_pkg::TOTAL_W-1:0]  sample_total,
  output logic signed [rmv_pkg::SAMPLE_W-1:0] mean_out,
  output logic        [rmv_pkg::SUM_W-1:0]    variance_out,
  output logic        [rmv_pkg::ROOT_W-1:0]   stddev_out
);

  localparam int MW  = rmv_pkg::MEAN_W;
  localparam int SW  = rmv_pkg::SUM_W;
  localparam int PW  = rmv_pkg::PART_W;
  localparam int XW  = rmv_pkg::PROD_W;
  localparam int RW  = rmv_pkg::ROOT_W;
  localparam int CW  = COUNT_BITS;
  localparam int TW  = rmv_pkg::TOTAL_W;

  // Statistics state
  logic [CW-1:0]        count;
  logic signed [MW-1:0] mean;
  logic [SW-1:0]        sum;

  // Working registers
  logic signed [MW-1:0] scaled;
  logic                 dneg;
  logic [MW-1:0]        mag1;
  logic [MW-1:0]        mag2;

  // Divider: dividend shifts out, quotient shifts in
  logic [SW-1:0]        dvd;
  logic [CW-1:0]        rem;
  logic [CW-1:0]        dsr;

  // Deviation product
  logic [2*PW-1:0]      pp;
  logic [1:0]           pp_pos;
  logic [XW-1:0]        acc;

  // Square root
  logic [SW-1:0]        sq_v;
  logic [RW+1:0]        sq_r;
  logic [RW-1:0]        sq_q;

  // Combinational helpers
  logic                 lt;
  logic [MW-1:0]        mag;
  logic [CW:0]          rem_sh;
  logic [CW+1:0]        div_diff;
  logic [MW-1:0]        quo;
  logic [PW-1:0]        a_part;
  logic [PW-1:0]        b_part;
  logic [XW-1:0]        pp_shifted;
  logic [SW-1:0]        term;
  logic [SW:0]          sum_add;
  logic [RW+3:0]        root_sh;
  logic [RW+4:0]        root_diff;
  logic [SW-1:0]        count_wide;

  assign stat.multi = (count > CW'(1));

  // Magnitude of the sample's offset from the current mean
  assign lt  = (scaled < mean);
  assign mag = lt ? MW'(mean - scaled) : MW'(scaled - mean);

  // Restoring division step
  assign rem_sh   = {rem, dvd[SW-1]};
  assign div_diff = {1'b0, rem_sh} - {2'b00, dsr};
  assign quo      = dvd[MW-1:0];

  // Partial product operand select
  assign a_part = cmd.mul_idx[0] ? mag1[MW-1:PW] : mag1[PW-1:0];
  assign b_part = cmd.mul_idx[1] ? mag2[MW-1:PW] : mag2[PW-1:0];

  always_comb begin
    case (pp_pos)
      2'd0:    pp_shifted = XW'(pp);
      2'd1:    pp_shifted = XW'(pp) << PW;
      2'd2:    pp_shifted = XW'(pp) << (2 * PW);
      default: pp_shifted = '0;
    endcase
  end

  // Saturating sum update
  assign term    = acc[XW-1 -: SW];
  assign sum_add = {1'b0, sum} + {1'b0, term};

  // Square root digit step
  assign root_sh   = {sq_r, sq_v[SW-1 -: 2]};
  assign root_diff = {1'b0, root_sh} - {3'b000, sq_q, 2'b01};

  // Count shown saturated at the output width
  assign count_wide = SW'(count);

  // Statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mean  <= '0;
      sum   <= '0;
    end else begin
      if (cmd.take && (count != '1)) begin
        count <= count + 1'b1;
      end
      if (cmd.mean_upd) begin
        mean <= dneg ? MW'(mean - quo) : MW'(mean + quo);
      end
      if (cmd.sum_upd) begin
        sum <= sum_add[SW] ? '1 : sum_add[SW-1:0];
      end
    end
  end

  // Deviations and shared divider
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      scaled <= {sample, {rmv_pkg::MEAN_EXTRA{1'b0}}};
    end
    if (cmd.delta) begin
      dneg <= lt;
      mag1 <= mag;
      dvd  <= SW'(mag);
      rem  <= '0;
      dsr  <= count;
    end else if (cmd.div_load_var) begin
      dvd  <= sum;
      rem  <= '0;
      dsr  <= count - CW'(1);
    end else if (cmd.var_zero) begin
      dvd  <= '0;
    end else if (cmd.div_step) begin
      dvd  <= {dvd[SW-2:0], !div_diff[CW+1]};
      rem  <= div_diff[CW+1] ? rem_sh[CW-1:0] : div_diff[CW-1:0];
    end
    if (cmd.delta2) begin
      mag2 <= mag;
    end
  end

  // Deviation product over four partial products
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      pp     <= a_part * b_part;
      pp_pos <= 2'({1'b0, cmd.mul_idx[0]} + {1'b0, cmd.mul_idx[1]});
    end
    if (cmd.mean_upd) begin
      acc <= '0;
    end else if (cmd.mul_acc) begin
      acc <= acc + pp_shifted;
    end
  end

  // Square root, two radicand bits per step
  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      sq_v <= dvd;
      sq_r <= '0;
      sq_q <= '0;
    end else if (cmd.root_step) begin
      sq_v <= sq_v << 2;
      if (root_diff[RW+4]) begin
        sq_r <= root_sh[RW+1:0];
        sq_q <= {sq_q[RW-2:0], 1'b0};
      end else begin
        sq_r <= root_diff[RW+1:0];
        sq_q <= {sq_q[RW-2:0], 1'b1};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      sample_total <= (count_wide > SW'({TW{1'b1}})) ? '1 : count_wide[TW-1:0];
      mean_out     <= mean[MW-1:rmv_pkg::MEAN_EXTRA];
      variance_out <= dvd;
      stddev_out   <= sq_q;
    end
  end

endmodule

// ===== rtl/rmv_check.sv =====
// Port-level checker of the running statistics block and its bind to the top level.
`include "assert_macros.svh"

module rmv_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         sample_valid,
  input logic                         sample_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [rmv_pkg::TOTAL_W-1:0]  sample_total,
  input logic [rmv_pkg::SUM_W-1:0]    variance_out,
  input logic [rmv_pkg::ROOT_W-1:0]   stddev_out
);

  // A waiting result stays until it is taken
  `RMV_ASSERT_NXT(result_hold, result_valid && !result_ready, result_valid)

  // Reset leaves no result pending
  `RMV_ASSERT_RST(reset_clears, rst, !result_valid)

  // One sample at a time: busy right after a transfer
  `RMV_ASSERT_NXT(busy_after_take, sample_valid && sample_ready, !sample_ready)

  // Every result counts at least its own sample
  `RMV_ASSERT_IMP(count_nonzero, result_valid, sample_total != '0)

  // Below two samples there is no spread
  `RMV_ASSERT_IMP(no_spread_early, result_valid && (sample_total < 2),
                  (variance_out == '0) && (stddev_out == '0))

endmodule

bind running_mean_variance rmv_check u_rmv_check (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_ch.valid),
  .sample_ready (sample_ch.ready),
  .result_valid (result_ch.valid),
  .result_ready (result_ch.ready),
  .sample_total (result_ch.sample_total),
  .variance_out (result_ch.variance_out),
  .stddev_out   (result_ch.stddev_out)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the running mean and variance block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SAMPLE_W      = rmv_pkg::SAMPLE_W;
  localparam int          TOTAL_W       = rmv_pkg::TOTAL_W;
  localparam int          SUM_W         = rmv_pkg::SUM_W;
  localparam int          ROOT_W        = rmv_pkg::ROOT_W;
  localparam int          COUNT_BITS    = rmv_pkg::COUNT_BITS_DEF;
  localparam logic [63:0] COUNT_MAX     = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int          RANDOM_ITEMS  = 750;
  localparam int          HOLD_AT       = 150;    // accepted samples before the long hold-off
  localparam int          HOLD_CYCLES   = 1500;
  localparam int          PAUSE_AT      = 500;    // random index where the sender drains
  localparam int          CALM_FIRST    = 300;    // random indexes with no idling
  localparam int          CALM_LAST     = 379;
  localparam int          SETTLE_CYCLES = 400;
  localparam int          CYCLE_LIMIT   = 1_000_000;

  // One result as the block presents it
  typedef struct packed {
    logic        [TOTAL_W-1:0]  total;
    logic signed [SAMPLE_W-1:0] mean;
    logic        [SUM_W-1:0]    variance;
    logic        [ROOT_W-1:0]   stddev;
  } stats_t;

  // One directed row: sample plus an optional hand-written result
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       typed;
    stats_t                     want;
  } stim_row_t;

  logic clk;
  logic rst;

  rmv_sample_if sample_ch ();
  rmv_result_if result_ch ();

  running_mean_variance uut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // Predictor state
  logic [63:0]    tally;
  longint signed  mean_acc;      // 48-bit mean, 16 extra fraction bits
  logic [63:0]    dev_sum;

  stats_t         expected_stats[$];
  stim_row_t      stim_rows[$];
  int             open_rows;
  int             errors = 0;
  int             accepted;
  bit             calm;
  int             cycles = 0;
  stats_t         seen_stats;
  stats_t         due_stats;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Welford update of the predictor state; returns the result of one sample
  function automatic stats_t welford_update(input logic signed [SAMPLE_W-1:0] s);
    longint signed  scaled;
    longint signed  delta;
    longint signed  delta2;
    logic [63:0]    mag1;
    logic [63:0]    mag2;
    logic [63:0]    step;
    logic [63:0]    term;
    logic [127:0]   prod;
    logic [64:0]    acc;
    logic [63:0]    variance;
    logic [63:0]    rem;
    logic [63:0]    root;
    logic [63:0]    bitv;
    stats_t         r;
    scaled = longint'(s) * 65536;
    if (tally < COUNT_MAX) tally = tally + 64'd1;

    // mean moves by the deviation over the count, truncated toward zero
    delta = scaled - mean_acc;
    mag1 = (delta < 0) ? 64'(-delta) : 64'(delta);
    step = mag1 / tally;
    if (delta < 0) mean_acc = mean_acc - longint'(step);
    else mean_acc = mean_acc + longint'(step);

    // product of old and new deviation, >> 32, saturated
    delta2 = scaled - mean_acc;
    mag2 = (delta2 < 0) ? 64'(-delta2) : 64'(delta2);
    prod = {64'd0, mag1} * {64'd0, mag2};
    term = (prod[127:96] != 32'd0) ? '1 : prod[95:32];
    acc = {1'b0, dev_sum} + {1'b0, term};
    dev_sum = acc[64] ? '1 : acc[63:0];

    variance = (tally > 64'd1) ? dev_sum / (tally - 64'd1) : 64'd0;

    // floor square root, two bits at a time
    rem = variance;
    root = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end

    r.total = (tally > 64'hFFFF_FFFF) ? '1 : tally[31:0];
    r.mean = mean_acc[47:16];
    r.variance = variance;
    r.stddev = root[31:0];
    return r;
  endfunction

  task automatic add_row(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                         input stats_t want);
    stim_row_t row;
    row.sample = s;
    row.typed = typed;
    row.want = want;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // Offer one sample after a random gap; log its expected result on transfer
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                              input stats_t want);
    int     gap;
    stats_t predicted;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = welford_update(s);
    expected_stats.insert(expected_stats.size(), typed ? want : predicted);
    accepted++;
  endtask

  // Result receiver: random stalls, one long hold-off
  initial begin : receiver
    int stall;
    bit hold_done;
    hold_done = 1'b0;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen_stats.total = result_ch.sample_total;
      seen_stats.mean = result_ch.mean_out;
      seen_stats.variance = result_ch.variance_out;
      seen_stats.stddev = result_ch.stddev_out;
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result transfer, total %0d", $time, seen_stats.total);
        errors++;
      end else begin
        due_stats = expected_stats.pop_front();
        if (seen_stats.total !== due_stats.total) begin
          $display("%0t: sample_total expected %0d, got %0d", $time, due_stats.total,
                   seen_stats.total);
          errors++;
        end
        if (seen_stats.mean !== due_stats.mean) begin
          $display("%0t: mean_out expected %h, got %h", $time, due_stats.mean,
                   seen_stats.mean);
          errors++;
        end
        if (seen_stats.variance !== due_stats.variance) begin
          $display("%0t: variance_out expected %h, got %h", $time, due_stats.variance,
                   seen_stats.variance);
          errors++;
        end
        if (seen_stats.stddev !== due_stats.stddev) begin
          $display("%0t: stddev_out expected %h, got %h", $time, due_stats.stddev,
                   seen_stats.stddev);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] s;
    int                         sel;
    int                         wbits;
    stats_t                     none;
    none = '0;
    accepted = 0;
    calm = 1'b0;
    tally = '0;
    mean_acc = 0;
    dev_sum = '0;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;

    // Opening rows: repeated sample after reset gives zero variance
    add_row(32'h0001_8000, 1'b1, '{32'd1, 32'h0001_8000, 64'd0, 32'd0});
    add_row(32'h0001_8000, 1'b1, '{32'd2, 32'h0001_8000, 64'd0, 32'd0});
    add_row(32'h0001_8000, 1'b1, '{32'd3, 32'h0001_8000, 64'd0, 32'd0});
    // one LSB either side: mean step truncates toward zero
    add_row(32'h0001_8001, 1'b0, none);
    add_row(32'h0001_7FFF, 1'b0, none);
    add_row(32'h0000_0000, 1'b0, none);
    add_row(32'hFFFF_FFFF, 1'b0, none);
    add_row(32'h0000_0001, 1'b0, none);
    // full-scale extremes; the pair leaves the mean near zero
    add_row(32'h7FFF_FFFF, 1'b0, none);
    add_row(32'h8000_0000, 1'b0, none);
    add_row(32'hFFFF_0000, 1'b0, none);
    add_row(32'h0001_0000, 1'b0, none);
    add_row(32'h0555_5555, 1'b0, none);
    add_row(32'hFAAA_AAAA, 1'b0, none);
    open_rows = stim_rows.size();
    // Closing rows: alternating extremes drive the deviation sum into saturation
    for (int k = 0; k < 4; k++) begin
      add_row(32'h7FFF_FFFF, 1'b0, none);
      add_row(32'h8000_0000, 1'b0, none);
    end
    add_row(32'h0000_0000, 1'b0, none);
    add_row(32'h0001_0000, 1'b0, none);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < open_rows; i++)
      offer_sample(stim_rows[i].sample, stim_rows[i].typed, stim_rows[i].want);

    // Random samples: moderate magnitudes so the sum stays clear of saturation
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= CALM_FIRST && i <= CALM_LAST);
      if (i == PAUSE_AT) begin
        sample_ch.valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        s = mean_acc[47:16];
      end else if (sel < 15) begin
        s = $signed($urandom_range(0, 6)) - 3;
      end else begin
        wbits = $urandom_range(1, 27);
        s = $urandom & ((32'd1 << wbits) - 32'd1);
        if ($urandom_range(0, 1) == 1) s = -s;
      end
      offer_sample(s, 1'b0, none);
    end
    calm = 1'b0;

    for (int i = open_rows; i < stim_rows.size(); i++)
      offer_sample(stim_rows[i].sample, stim_rows[i].typed, stim_rows[i].want);
    sample_ch.valid <= 1'b0;

    // Drain, then watch for stray results
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
